FILE: hw/rtl/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types, constants and arithmetic helpers for the dense matrix
// multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmm_pkg;

    // Field widths of the stream items
    localparam int IDX_W       = 4;    // row / column index fields
    localparam int VAL_W       = 16;   // Q8.8 element
    localparam int DIM_W       = 5;    // size registers
    localparam int PROD_W      = 2 * VAL_W;
    localparam int ACC_W       = 36;   // Q20.16 result
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;

    localparam int IN_TDATA_W  = 2 * IDX_W + VAL_W;                 // 24
    localparam int OUT_PAY_W   = 2 * IDX_W + ACC_W;                 // 44
    localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;         // 48
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_PAY_W;

    // Largest size the index fields can express
    localparam int FIELD_LIMIT = 1 << IDX_W;
    localparam int DEF_MAX_DIM = 16;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = CFG_IDX_W'(2);

    // Item kinds carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_a;     // write the input element into the A store
        logic             wr_b;     // write the input element into the B store
        logic             issue;    // one multiply-accumulate step is offered
        logic             first;    // first step of a dot product
        logic             last;     // last step of a dot product
        logic             row_end;  // dot product is the final column of the row
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] step;
    } dmm_cmd_t;

    // Clamp a size register to 1 .. lim
    function automatic logic [DIM_W-1:0] dim_in_use(
        input logic [DIM_W-1:0] r,
        input logic [DIM_W-1:0] lim
    );
        logic [DIM_W-1:0] d;
        if (r == '0)
            d = DIM_W'(1);
        else if (r > lim)
            d = lim;
        else
            d = r;
        return d;
    endfunction

    // Add a product to the accumulator, saturating to the 36-bit range
    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [ACC_W:0]   sum;
        logic signed [ACC_W-1:0] res;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - PROD_W){prod[PROD_W-1]}}, prod};
        if (sum[ACC_W] != sum[ACC_W-1])
            res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            res = sum[ACC_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dense_matrix_multiply.sv
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// C = A x B on signed Q8.8 elements, one row of C per compute item, each
// element an exact Q20.16 dot product saturated to 36 bits.
// ----------------------------------------------------------------------------
// Load items (tuser = load A / load B) write one element into the on-chip
// A or B store. A compute item (tuser = compute) names a row of C; the
// block then runs one shared multiply-accumulate unit, one step per cycle
// unless stalled, for inner_dim x cols_b steps and emits cols_b results in
// column order, tlast on the final column. A compute item holds the input
// until its final step is issued; the last result then passes the store
// read and product registers into the output register, and a following
// item is taken meanwhile. Any cycle on which a result waits untaken
// stalls the whole pipeline. Size registers are written through cfg_we /
// cfg_index / cfg_data; the user must write them only while idle, the
// block does not enforce this. Stores need no clearing after reset; every
// entry a compute reads must have been loaded first.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_matrix_multiply #(
    parameter int MAX_DIM = dmm_pkg::DEF_MAX_DIM
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // Size register write port
    input  wire                               cfg_we,
    input  wire  [dmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [dmm_pkg::DIM_W-1:0]         cfg_data,
    // Input items
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [dmm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // row_index, col_index,
                                                             // element_value
    input  wire  [dmm_pkg::OP_W-1:0]          s_axis_tuser,  // operation
    // Result items
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [dmm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // out_row, out_col,
                                                             // product_value, zero pad
    output logic                              m_axis_tlast   // last_in_row
);

    import dmm_pkg::*;

    dmm_cmd_t                cmd;
    logic                    stall;
    logic [IDX_W-1:0]        in_row, in_col;
    logic [VAL_W-1:0]        in_value;
    logic [IDX_W-1:0]        out_row, out_col;
    logic signed [ACC_W-1:0] out_value;

    // Unpack the input transfer
    assign in_row   = s_axis_tdata[IDX_W-1:0];
    assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    dmm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_row    (in_row),
        .in_col    (in_col),
        .stall     (stall),
        .cmd       (cmd)
    );

    dmm_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stall     (stall),
        .in_row    (in_row),
        .in_col    (in_col),
        .in_value  (in_value),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_axis_tlast)
    );

    // Pack the result transfer
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_value, out_col, out_row};

endmodule

`default_nettype wire

FILE: hw/rtl/dmm_ram.sv
// ----------------------------------------------------------------------------
// dmm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dmm_ctrl.sv
// ----------------------------------------------------------------------------
// dmm_ctrl
// Size registers and the sequencer: decodes input items and walks the
// column and inner-step counters of a row computation.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_ctrl #(
    parameter int MAX_DIM = dmm_pkg::DEF_MAX_DIM
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire  [dmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [dmm_pkg::DIM_W-1:0]      cfg_data,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [dmm_pkg::OP_W-1:0]       in_op,
    input  wire  [dmm_pkg::IDX_W-1:0]      in_row,
    input  wire  [dmm_pkg::IDX_W-1:0]      in_col,
    input  wire                            stall,
    output dmm_pkg::dmm_cmd_t              cmd
);

    import dmm_pkg::*;

    localparam logic [DIM_W-1:0] DIM_LIM =
        DIM_W'((MAX_DIM < FIELD_LIMIT) ? MAX_DIM : FIELD_LIMIT);

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] t_reg, t_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] m_use, k_use, n_use;
    logic [DIM_W-1:0] k_last, n_last;
    logic             accept;
    logic             adv;
    logic             load_ok;
    logic             row_ok;
    logic             t_end, j_end;
    op_t              op;

    assign op      = op_t'(in_op);
    assign adv     = !stall;
    assign m_use   = dim_in_use(rows_a_reg, DIM_LIM);
    assign k_use   = dim_in_use(inner_dim_reg, DIM_LIM);
    assign n_use   = dim_in_use(cols_b_reg, DIM_LIM);
    assign k_last  = k_use - DIM_W'(1);
    assign n_last  = n_use - DIM_W'(1);
    assign t_end   = (t_reg == k_last[IDX_W-1:0]);
    assign j_end   = (j_reg == n_last[IDX_W-1:0]);
    assign accept  = in_valid && in_ready;
    assign load_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    assign row_ok  = ({1'b0, in_row} < m_use);

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_COMPUTE && row_ok)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (adv && t_end && j_end)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Counters and the latched row
    always_comb
    begin
        row_next = row_reg;
        t_next   = t_reg;
        j_next   = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_COMPUTE)
                begin
                    row_next = in_row;
                    t_next   = '0;
                    j_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (t_end)
                    begin
                        t_next = '0;
                        j_next = j_reg + IDX_W'(1);
                    end
                    else
                    begin
                        t_next = t_reg + IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.row     = row_reg;
        cmd.col     = j_reg;
        cmd.step    = t_reg;
        cmd.first   = (t_reg == '0);
        cmd.last    = t_end;
        cmd.row_end = j_end && t_end;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.wr_a   = accept && (op == OP_LOAD_A) && load_ok;
                cmd.wr_b   = accept && (op == OP_LOAD_B) && load_ok;
            end
            ST_RUN:
            begin
                cmd.issue  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            t_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            t_reg     <= t_next;
            j_reg     <= j_next;
        end
    end

    // Checks
    a_one_store: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_a && cmd.wr_b))
        else $error("dmm_ctrl: both stores written by one item");

    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ({1'b0, t_reg} < k_use) && ({1'b0, j_reg} < n_use))
        else $error("dmm_ctrl: step or column counter beyond size in use");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && stall) |=> $stable(t_reg) && $stable(j_reg))
        else $error("dmm_ctrl: counters moved during a stall");

endmodule

`default_nettype wire

FILE: hw/rtl/dmm_dp.sv
// ----------------------------------------------------------------------------
// dmm_dp
// Datapath: A and B stores, one multiply-accumulate pipeline and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_dp #(
    parameter int MAX_DIM = dmm_pkg::DEF_MAX_DIM
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  dmm_pkg::dmm_cmd_t                cmd,
    output logic                             stall,
    input  wire  [dmm_pkg::IDX_W-1:0]        in_row,
    input  wire  [dmm_pkg::IDX_W-1:0]        in_col,
    input  wire  [dmm_pkg::VAL_W-1:0]        in_value,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [dmm_pkg::IDX_W-1:0]        out_row,
    output logic [dmm_pkg::IDX_W-1:0]        out_col,
    output logic signed [dmm_pkg::ACC_W-1:0] out_value,
    output logic                             out_last
);

    import dmm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                     adv;
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        a_raddr, b_raddr;
    logic                     re;
    logic [VAL_W-1:0]         a_rdata, b_rdata;

    logic                     s1_v_reg, s2_v_reg;
    logic                     s1_first_reg, s1_last_reg, s1_end_reg;
    logic                     s2_first_reg, s2_last_reg, s2_end_reg;
    logic [IDX_W-1:0]         s1_row_reg, s1_col_reg, s2_row_reg, s2_col_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_last_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [ACC_W-1:0]  out_value_reg;
    logic                     emit;

    // Stall the whole pipeline while a result waits to be taken
    assign stall = out_valid_reg && !out_ready;
    assign adv   = !stall;

    // Store addresses: row * MAX_DIM + column
    assign waddr   = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);
    assign a_raddr = ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.step);
    assign b_raddr = ADDR_W'(cmd.step) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col);
    assign re      = cmd.issue && adv;

    dmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (cmd.wr_a),
        .waddr (waddr),
        .wdata (in_value),
        .re    (re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    dmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk   (clk),
        .we    (cmd.wr_b),
        .waddr (waddr),
        .wdata (in_value),
        .re    (re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    // Stage tags and the multiplier register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last;
            s1_end_reg   <= cmd.row_end;
            s1_row_reg   <= cmd.row;
            s1_col_reg   <= cmd.col;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_end_reg   <= s1_end_reg;
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            prod_reg     <= $signed(a_rdata) * $signed(b_rdata);
        end
    end

    // Accumulate with saturation; restart on the first step
    assign acc_next = sat_acc(s2_first_reg ? '0 : acc_reg, prod_reg);
    assign emit     = adv && s2_v_reg && s2_last_reg;

    always_ff @(posedge clk)
    begin
        if (adv && s2_v_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg   <= s2_row_reg;
            out_col_reg   <= s2_col_reg;
            out_value_reg <= acc_next;
            out_last_reg  <= s2_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    // Checks
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("dmm_dp: finished dot product did not reach the output");

    a_row_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && s2_end_reg) |-> s2_last_reg)
        else $error("dmm_dp: row end flagged on an inner step");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> $stable(prod_reg) && $stable(s2_v_reg))
        else $error("dmm_dp: pipeline moved during a stall");

endmodule

`default_nettype wire

FILE: tb/sv/dense_matrix_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_multiply_tb
// Self-checking bench for the dense matrix multiply block. Loads A and B
// elements over the input stream, asks for rows of C, and compares every
// emitted element against a behavioral model held in the bench. A short
// table of directed items with hand-derived answers comes first. Random
// phases with changing matrix sizes follow, each loading every store entry
// a compute will read before it runs. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module dense_matrix_multiply_tb;

    import dmm_pkg::*;

    localparam int DIM_LIMIT   = (DEF_MAX_DIM < FIELD_LIMIT) ? DEF_MAX_DIM : FIELD_LIMIT;
    localparam int ITEM_TARGET = 420;
    localparam int PHASE_OPS   = 12;
    localparam int FULL_PHASE  = 3;    // phase run at the largest size, with the hold-off
    localparam int STEADY_PHASE = 1;   // phase with no idling on either side
    localparam int PAUSE_PHASE = 2;    // phase in which the sender waits for the drain
    localparam int SETTLE      = 300;  // covers one full row of MAC steps plus the tail
    localparam int HOLD_CYCLES = 600;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam longint C_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint C_MIN = -(longint'(1) <<< (ACC_W - 1));

    typedef enum logic {
        STEP_ITEM,
        STEP_CFG
    } step_kind_t;

    typedef enum logic [1:0] {
        CHK_PREDICT,   // take the answer from the model
        CHK_NONE,      // no C element may come
        CHK_VALUE      // one element, value given in the table
    } chk_t;

    typedef struct packed {
        step_kind_t              kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [OP_W-1:0]         op;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic [VAL_W-1:0]        val;      // also the size value for a register write
        chk_t                    mode;
        logic signed [ACC_W-1:0] c_value;
    } step_t;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [ACC_W-1:0] value;
        logic                    last;
    } c_elem_t;

    localparam int N_DIRECTED = 21;
    localparam step_t DIRECTED [N_DIRECTED] = '{
        // one by one by one sizes
        '{STEP_CFG,  REG_ROWS_A,    OP_LOAD_A,   4'd0,  4'd0,  16'd1,    CHK_NONE,    36'sd0},
        '{STEP_CFG,  REG_INNER_DIM, OP_LOAD_A,   4'd0,  4'd0,  16'd1,    CHK_NONE,    36'sd0},
        '{STEP_CFG,  REG_COLS_B,    OP_LOAD_A,   4'd0,  4'd0,  16'd1,    CHK_NONE,    36'sd0},
        // largest positive times largest positive
        '{STEP_ITEM, REG_ROWS_A,    OP_LOAD_A,   4'd0,  4'd0,  16'h7FFF, CHK_PREDICT, 36'sd0},
        '{STEP_ITEM, REG_ROWS_A,    OP_LOAD_B,   4'd0,  4'd0,  16'h7FFF, CHK_PREDICT, 36'sd0},
        '{STEP_ITEM, REG_ROWS_A,    OP_COMPUTE,  4'd0,  4'd0,  16'h0000, CHK_VALUE,
          36'sh0_3FFF_0001},
        // largest positive times most negative; column and value fields ignored
        '{STEP_ITEM, REG_ROWS_A,    OP_LOAD_B,   4'd0,  4'd0,  16'h8000, CHK_PREDICT, 36'sd0},
        '{STEP_ITEM, REG_ROWS_A,    OP_COMPUTE,  4'd0,  4'd15, 16'hFFFF, CHK_VALUE,
          -36'sh0_3FFF_8000},
        // most negative squared
        '{STEP_ITEM, REG_ROWS_A,    OP_LOAD_A,   4'd0,  4'd0,  16'h8000, CHK_PREDICT, 36'sd0},
        '{STEP_ITEM, REG_ROWS_A,    OP_COMPUTE,  4'd0,  4'd0,  16'h0000, CHK_VALUE,
          36'sh0_4000_0000},
        // row outside rows_a gives nothing
        '{STEP_ITEM, REG_ROWS_A,    OP_COMPUTE,  4'd1,  4'd0,  16'h0000, CHK_NONE,    36'sd0},
        // reserved code touches nothing
        '{STEP_ITEM, REG_ROWS_A,    OP_RESERVED, 4'd15, 4'd15, 16'hFFFF, CHK_NONE,    36'sd0},
        '{STEP_ITEM, REG_ROWS_A,    OP_COMPUTE,  4'd0,  4'd0,  16'h0000, CHK_VALUE,
          36'sh0_4000_0000},
        // zero sizes act as one, oversize rows act as the limit
        '{STEP_CFG,  REG_INNER_DIM, OP_LOAD_A,   4'd0,  4'd0,  16'd0,    CHK_NONE,    36'sd0},
        '{STEP_CFG,  REG_COLS_B,    OP_LOAD_A,   4'd0,  4'd0,  16'd0,    CHK_NONE,    36'sd0},
        '{STEP_CFG,  REG_ROWS_A,    OP_LOAD_A,   4'd0,  4'd0,  16'd31,   CHK_NONE,    36'sd0},
        '{STEP_ITEM, REG_ROWS_A,    OP_LOAD_A,   4'd15, 4'd0,  16'h0100, CHK_PREDICT, 36'sd0},
        '{STEP_ITEM, REG_ROWS_A,    OP_COMPUTE,  4'd15, 4'd0,  16'h0000, CHK_VALUE,
          -36'sh0_0080_0000},
        // far corner of both stores
        '{STEP_ITEM, REG_ROWS_A,    OP_LOAD_A,   4'd15, 4'd15, 16'h0100, CHK_PREDICT, 36'sd0},
        '{STEP_ITEM, REG_ROWS_A,    OP_LOAD_B,   4'd15, 4'd15, 16'hFFFF, CHK_PREDICT, 36'sd0},
        '{STEP_ITEM, REG_ROWS_A,    OP_COMPUTE,  4'd0,  4'd7,  16'h1234, CHK_VALUE,
          36'sh0_4000_0000}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // row_index, col_index, element_value
    logic [OP_W-1:0]        s_axis_tuser;   // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // out_row, out_col, product_value, zero pad
    logic                   m_axis_tlast;   // last_in_row

    // Bench copy of the block state
    logic signed [VAL_W-1:0] a_mem [DIM_LIMIT][DIM_LIMIT];
    logic signed [VAL_W-1:0] b_mem [DIM_LIMIT][DIM_LIMIT];
    bit                      a_set [DIM_LIMIT][DIM_LIMIT];
    bit                      b_set [DIM_LIMIT][DIM_LIMIT];
    logic [DIM_W-1:0]        size_reg [3];

    c_elem_t pending_c [$];

    int  mismatches;
    int  c_checked;
    int  items_sent;
    int  computes_sent;
    int  size_writes;
    int  phase_no;
    bit  steady;
    bit  hold_request;
    bit  hold_done;

    dense_matrix_multiply uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Size register value as the block uses it
    function automatic int used_dim(input logic [DIM_W-1:0] r);
        if (r == '0)
            return 1;
        if (r > DIM_LIMIT)
            return DIM_LIMIT;
        return int'(r);
    endfunction

    // Work out every C element of one row, in column order
    task automatic predict_c_row(input logic [IDX_W-1:0] r);
        int      m;
        int      k;
        int      n;
        longint  acc;
        c_elem_t e;
        m = used_dim(size_reg[REG_ROWS_A]);
        k = used_dim(size_reg[REG_INNER_DIM]);
        n = used_dim(size_reg[REG_COLS_B]);
        if (int'(r) >= m)
            return;
        for (int j = 0; j < n; j++)
        begin
            acc = 0;
            for (int t = 0; t < k; t++)
            begin
                acc += longint'(a_mem[r][t]) * longint'(b_mem[t][j]);
                if (acc > C_MAX)
                    acc = C_MAX;
                else if (acc < C_MIN)
                    acc = C_MIN;
            end
            e.row   = r;
            e.col   = IDX_W'(j);
            e.value = acc[ACC_W-1:0];
            e.last  = (j == n - 1);
            pending_c.push_back(e);
        end
    endtask

    // Offer one item, wait for its transfer, then update the model.
    // Entered and left at a falling edge.
    task automatic send_item(
        input logic [OP_W-1:0]        op,
        input logic [IDX_W-1:0]       row,
        input logic [IDX_W-1:0]       col,
        input logic [VAL_W-1:0]       val,
        input chk_t                   mode,
        input logic signed [ACC_W-1:0] c_value
    );
        c_elem_t e;
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, col, row};
        do
            @(posedge clk);
        while (!s_axis_tready);

        case (op)
            OP_LOAD_A:
            begin
                a_mem[row][col] = val;
                a_set[row][col] = 1'b1;
                items_sent++;
            end
            OP_LOAD_B:
            begin
                b_mem[row][col] = val;
                b_set[row][col] = 1'b1;
                items_sent++;
            end
            OP_COMPUTE:
            begin
                items_sent++;
                computes_sent++;
                if (mode == CHK_VALUE)
                begin
                    e.row   = row;
                    e.col   = '0;
                    e.value = c_value;
                    e.last  = 1'b1;
                    pending_c.push_back(e);
                end
                else if (mode == CHK_PREDICT)
                    predict_c_row(row);
            end
            default:
                ;   // reserved code is dropped by the block
        endcase
        @(negedge clk);
    endtask

    // Drop the input and wait until every expected element has arrived
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_c.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write one size register; cfg_we drops again before the task returns so writes never overlap
    task automatic write_size(
        input logic [CFG_IDX_W-1:0] idx,
        input logic [DIM_W-1:0]     data
    );
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        size_reg[idx] = data;
        size_writes++;
        @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_element();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 16'h7FFF;
        if (roll < 20)
            return 16'h8000;
        if (roll < 25)
            return 16'h0000;
        return VAL_W'($urandom);
    endfunction

    // Mostly small sizes, with zero, the limit and oversize values mixed in
    function automatic logic [DIM_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 18)
            return DIM_W'(DIM_LIMIT);
        if (roll < 24)
            return DIM_W'($urandom_range(DIM_LIMIT + 1, (1 << DIM_W) - 1));
        return DIM_W'($urandom_range(1, 5));
    endfunction

    // Load every entry a compute of row r will read that is still unwritten
    task automatic fill_operands(input logic [IDX_W-1:0] r);
        int k;
        int n;
        k = used_dim(size_reg[REG_INNER_DIM]);
        n = used_dim(size_reg[REG_COLS_B]);
        for (int t = 0; t < k; t++)
            if (!a_set[r][t])
                send_item(OP_LOAD_A, r, IDX_W'(t), rand_element(), CHK_PREDICT, '0);
        for (int t = 0; t < k; t++)
            for (int j = 0; j < n; j++)
                if (!b_set[t][j])
                    send_item(OP_LOAD_B, IDX_W'(t), IDX_W'(j), rand_element(),
                              CHK_PREDICT, '0);
    endtask

    // One random phase: loads, computes and noise at the current sizes
    task automatic run_phase(input bit hold, input bit pause);
        int               roll;
        int               m;
        logic [IDX_W-1:0] r;
        m = used_dim(size_reg[REG_ROWS_A]);
        for (int i = 0; i < PHASE_OPS; i++)
        begin
            if (hold && i == 2)
                hold_request = 1'b1;
            if (pause && i == PHASE_OPS / 2)
                wait_drain();
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                send_item(($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B,
                          IDX_W'($urandom), IDX_W'($urandom), rand_element(),
                          CHK_PREDICT, '0);
            end
            else if (roll < 92)
            begin
                if ($urandom_range(0, 9) < 8)
                    r = IDX_W'($urandom_range(0, m - 1));
                else
                    r = IDX_W'($urandom);
                if (int'(r) < m)
                    fill_operands(r);
                send_item(OP_COMPUTE, r, IDX_W'($urandom), VAL_W'($urandom),
                          CHK_PREDICT, '0);
            end
            else
            begin
                send_item(OP_RESERVED, IDX_W'($urandom), IDX_W'($urandom),
                          VAL_W'($urandom), CHK_NONE, '0);
            end
        end
    endtask

    // Result side: random backpressure, a steady stretch, one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (steady)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 20);
        end
    end

    // Check each C element transfer against the oldest expectation
    always @(posedge clk)
    begin : c_monitor
        c_elem_t                 want;
        logic [IDX_W-1:0]        got_row;
        logic [IDX_W-1:0]        got_col;
        logic signed [ACC_W-1:0] got_value;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_row   = m_axis_tdata[IDX_W-1:0];
            got_col   = m_axis_tdata[2*IDX_W-1:IDX_W];
            got_value = m_axis_tdata[2*IDX_W+ACC_W-1:2*IDX_W];
            if (pending_c.size() == 0)
                report_mismatch($sformatf("unexpected C element row %0d col %0d",
                                          got_row, got_col));
            else
            begin
                want = pending_c.pop_front();
                c_checked++;
                if (got_row !== want.row)
                    report_mismatch($sformatf("row %0d, predicted %0d", got_row, want.row));
                if (got_col !== want.col)
                    report_mismatch($sformatf("row %0d: col %0d, predicted %0d",
                                              want.row, got_col, want.col));
                if (got_value !== want.value)
                    report_mismatch($sformatf("C[%0d][%0d] = %0d, predicted %0d",
                                              want.row, want.col, got_value, want.value));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("C[%0d][%0d] tlast %b, predicted %b",
                                              want.row, want.col, m_axis_tlast, want.last));
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        mismatches    = 0;
        c_checked     = 0;
        items_sent    = 0;
        computes_sent = 0;
        size_writes   = 0;
        size_reg[REG_ROWS_A]    = DIM_RESET;
        size_reg[REG_INNER_DIM] = DIM_RESET;
        size_reg[REG_COLS_B]    = DIM_RESET;
        for (int i = 0; i < DIM_LIMIT; i++)
            for (int j = 0; j < DIM_LIMIT; j++)
            begin
                a_mem[i][j] = '0;
                b_mem[i][j] = '0;
                a_set[i][j] = 1'b0;
                b_set[i][j] = 1'b0;
            end

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == STEP_CFG)
            begin
                wait_drain();
                write_size(DIRECTED[i].reg_idx, DIRECTED[i].val[DIM_W-1:0]);
            end
            else
                send_item(DIRECTED[i].op, DIRECTED[i].row, DIRECTED[i].col,
                          DIRECTED[i].val, DIRECTED[i].mode, DIRECTED[i].c_value);
        end

        // Random phases, each at sizes rewritten while idle (any register may keep its value)
        phase_no = 0;
        while (items_sent < ITEM_TARGET || phase_no <= FULL_PHASE)
        begin
            wait_drain();
            if (phase_no == FULL_PHASE)
            begin
                write_size(REG_ROWS_A, DIM_W'(DIM_LIMIT));
                write_size(REG_INNER_DIM, DIM_W'(DIM_LIMIT));
                write_size(REG_COLS_B, DIM_W'(DIM_LIMIT));
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                    write_size(REG_ROWS_A, pick_size());
                if ($urandom_range(0, 9) < 7)
                    write_size(REG_INNER_DIM, pick_size());
                if ($urandom_range(0, 9) < 7)
                    write_size(REG_COLS_B, pick_size());
            end
            steady = (phase_no == STEADY_PHASE);
            run_phase(phase_no == FULL_PHASE, phase_no == PAUSE_PHASE);
            phase_no++;
        end
        steady = 1'b0;
        wait_drain();

        $display("covered %0d load and compute transfers (%0d computes), %0d C elements checked",
                 items_sent, computes_sent, c_checked);
        $display("%0d size register writes over %0d random phases, one long output hold-off",
                 size_writes, phase_no);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
